[sv/mrcs_pkg.sv]
// Shared types, constants and helpers for the matrix row/column sorter.
// Depends on nothing; every other file refers to it by scoped names.
package mrcs_pkg;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int CNT_W       = 4;
    localparam int DATA_W      = 32;
    localparam int NUM_CELLS   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int SETTLE_LAST = NUM_CELLS + 1;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
    } out_item_t;

    // Control word broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic clear;
        logic shift;
        logic descend;
        logic ins_valid;
    } chain_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FEED,
        ST_SETTLE,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) r = CNT_W'(1);
        else if (v > maxv) r = maxv;
        return r;
    endfunction

endpackage

[sv/mrcs_cell.sv]
// One insertion-sort cell: holds one value and passes the displaced value on.
// Depends on mrcs_pkg.
module mrcs_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mrcs_pkg::chain_ctrl_t              ctrl,
    input  logic                               in_v,
    input  logic signed [mrcs_pkg::DATA_W-1:0] in_d,
    input  logic                               nb_v,
    input  logic signed [mrcs_pkg::DATA_W-1:0] nb_d,
    output logic                               hold_v,
    output logic signed [mrcs_pkg::DATA_W-1:0] hold_d,
    output logic                               pass_v,
    output logic signed [mrcs_pkg::DATA_W-1:0] pass_d
);

    logic                               hold_v_reg, hold_v_next;
    logic signed [mrcs_pkg::DATA_W-1:0] hold_d_reg, hold_d_next;
    logic                               pass_v_reg, pass_v_next;
    logic signed [mrcs_pkg::DATA_W-1:0] pass_d_reg, pass_d_next;
    logic                               take_new;

    assign take_new = ctrl.descend ? (in_d > hold_d_reg) : (in_d < hold_d_reg);

    always_comb begin
        hold_v_next = hold_v_reg;
        hold_d_next = hold_d_reg;
        pass_v_next = 1'b0;
        pass_d_next = pass_d_reg;
        if (ctrl.clear) begin
            hold_v_next = 1'b0;
        end else if (ctrl.shift) begin
            hold_v_next = nb_v;
            hold_d_next = nb_d;
        end else if (in_v) begin
            if (!hold_v_reg) begin
                hold_v_next = 1'b1;
                hold_d_next = in_d;
            end else if (take_new) begin
                hold_d_next = in_d;
                pass_v_next = 1'b1;
                pass_d_next = hold_d_reg;
            end else begin
                pass_v_next = 1'b1;
                pass_d_next = in_d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            pass_v_reg <= 1'b0;
        end else begin
            hold_v_reg <= hold_v_next;
            pass_v_reg <= pass_v_next;
        end
        hold_d_reg <= hold_d_next;
        pass_d_reg <= pass_d_next;
    end

    assign hold_v = hold_v_reg;
    assign hold_d = hold_d_reg;
    assign pass_v = pass_v_reg;
    assign pass_d = pass_d_reg;

endmodule

[sv/mrcs_chain.sv]
// Row of sorting cells; values enter at cell 0 and drain out of cell 0.
// Depends on mrcs_pkg and mrcs_cell.
module mrcs_chain (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mrcs_pkg::chain_ctrl_t              ctrl,
    input  logic signed [mrcs_pkg::DATA_W-1:0] ins_d,
    output logic signed [mrcs_pkg::DATA_W-1:0] head_d
);

    localparam int N = mrcs_pkg::NUM_CELLS;

    logic                               hv [N+1];
    logic signed [mrcs_pkg::DATA_W-1:0] hd [N+1];
    logic                               pv [N+1];
    logic signed [mrcs_pkg::DATA_W-1:0] pd [N+1];

    assign pv[0] = ctrl.ins_valid;
    assign pd[0] = ins_d;
    assign hv[N] = 1'b0;
    assign hd[N] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        mrcs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .in_v    (pv[i]),
            .in_d    (pd[i]),
            .nb_v    (hv[i+1]),
            .nb_d    (hd[i+1]),
            .hold_v  (hv[i]),
            .hold_d  (hd[i]),
            .pass_v  (pv[i+1]),
            .pass_d  (pd[i+1])
        );
    end

    assign head_d = hd[0];

endmodule

[sv/matrix_row_col_sort.sv]
// Top level of the matrix sorter: element store, sequencer and result register.
// Depends on mrcs_pkg and mrcs_chain.
//
//  Channel   Ports                   Direction  Contents
//  input     s_valid/s_ready/s_data  in         in_item_t: value, last
//  result    m_valid/m_ready/m_data  out        out_item_t: sorted_value, final_res
//  config    cfg_wen/cfg_addr/cfg_wdata in      row_count (0), col_count (1)
//
// While loading, s_ready is high and every offered item is taken. After the item
// marked last, each row of C elements is fed into the cell chain, left to settle
// and drained back into the element store, then each column of R elements alike.
// Each result is then read, registered and held until m_ready accepts it.
// Reset is synchronous on aresetn; the store itself is not cleared.
module matrix_row_col_sort (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mrcs_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mrcs_pkg::out_item_t  m_data,
    input  logic                 cfg_wen,
    input  logic                 cfg_addr,
    input  logic [mrcs_pkg::CNT_W-1:0] cfg_wdata
);

    localparam int AW = mrcs_pkg::ADDR_W;
    localparam int PW = mrcs_pkg::POS_W;
    localparam int CW = mrcs_pkg::CNT_W;
    localparam int DW = mrcs_pkg::DATA_W;

    mrcs_pkg::state_t state_reg, state_next;

    logic [CW-1:0] row_count_reg, col_count_reg;
    logic [CW-1:0] rows_c, cols_c, line_len, line_cnt, step;
    logic [PW-1:0] n_elem;

    logic [PW-1:0] pos_reg, pos_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] line_reg, line_next;
    logic [CW-1:0] settle_reg, settle_next;
    logic          col_pass_reg, col_pass_next;
    logic          ins_pend_reg;
    logic [PW-1:0] eidx_reg, eidx_next;

    logic          m_valid_reg;
    mrcs_pkg::out_item_t out_reg;

    logic signed [DW-1:0] mem [mrcs_pkg::STORE_DEPTH];
    logic signed [DW-1:0] rdata_reg;
    logic                 we;
    logic [AW-1:0]        wa;
    logic signed [DW-1:0] wd;

    mrcs_pkg::chain_ctrl_t ctrl;
    logic signed [DW-1:0]  head_d;
    logic                  s_acc;

    assign rows_c   = mrcs_pkg::clamp_count(row_count_reg, CW'(mrcs_pkg::MAX_ROWS));
    assign cols_c   = mrcs_pkg::clamp_count(col_count_reg, CW'(mrcs_pkg::MAX_COLS));
    assign n_elem   = PW'(rows_c) * PW'(cols_c);
    assign line_len = col_pass_reg ? rows_c : cols_c;
    assign line_cnt = col_pass_reg ? cols_c : rows_c;
    assign step     = col_pass_reg ? cols_c : CW'(1);
    assign s_acc    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= CW'(mrcs_pkg::MAX_ROWS);
            col_count_reg <= CW'(mrcs_pkg::MAX_COLS);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                mrcs_pkg::REG_ROW_COUNT: row_count_reg <= cfg_wdata;
                mrcs_pkg::REG_COL_COUNT: col_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mrcs_pkg::ST_LOAD:
                if (s_acc && s_data.last) state_next = mrcs_pkg::ST_FEED;
            mrcs_pkg::ST_FEED:
                if (j_reg == line_len - CW'(1)) state_next = mrcs_pkg::ST_SETTLE;
            mrcs_pkg::ST_SETTLE:
                if (settle_reg == CW'(mrcs_pkg::SETTLE_LAST)) state_next = mrcs_pkg::ST_DRAIN;
            mrcs_pkg::ST_DRAIN:
                if (j_reg == line_len - CW'(1)) begin
                    if (line_reg == line_cnt - CW'(1) && col_pass_reg)
                        state_next = mrcs_pkg::ST_EMIT_RD;
                    else
                        state_next = mrcs_pkg::ST_FEED;
                end
            mrcs_pkg::ST_EMIT_RD:   state_next = mrcs_pkg::ST_EMIT_LD;
            mrcs_pkg::ST_EMIT_LD:   state_next = mrcs_pkg::ST_EMIT_WAIT;
            mrcs_pkg::ST_EMIT_WAIT:
                if (m_ready) begin
                    state_next = (eidx_reg == n_elem - PW'(1)) ? mrcs_pkg::ST_LOAD
                                                               : mrcs_pkg::ST_EMIT_RD;
                end
            default: state_next = mrcs_pkg::ST_LOAD;
        endcase
    end

    // Counters, pointers and control outputs.
    always_comb begin
        pos_next      = pos_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        base_next     = base_reg;
        j_next        = j_reg;
        line_next     = line_reg;
        settle_next   = settle_reg;
        col_pass_next = col_pass_reg;
        eidx_next     = eidx_reg;
        we            = 1'b0;
        wa            = pos_reg[AW-1:0];
        wd            = s_data.value;
        ctrl          = '0;
        ctrl.descend  = col_pass_reg;
        ctrl.ins_valid = ins_pend_reg;
        unique case (state_reg)
            mrcs_pkg::ST_LOAD: begin
                if (s_acc) begin
                    we = (pos_reg < n_elem);
                    if (pos_reg < PW'(mrcs_pkg::STORE_DEPTH)) pos_next = pos_reg + PW'(1);
                    if (s_data.last) begin
                        pos_next      = '0;
                        col_pass_next = 1'b0;
                        base_next     = '0;
                        rd_ptr_next   = '0;
                        line_next     = '0;
                        j_next        = '0;
                        ctrl.clear    = 1'b1;
                    end
                end
            end
            mrcs_pkg::ST_FEED: begin
                rd_ptr_next = AW'({1'b0, rd_ptr_reg} + (AW+1)'(step));
                j_next      = j_reg + CW'(1);
                if (j_reg == line_len - CW'(1)) settle_next = '0;
            end
            mrcs_pkg::ST_SETTLE: begin
                settle_next = settle_reg + CW'(1);
                j_next      = '0;
                wr_ptr_next = base_reg;
            end
            mrcs_pkg::ST_DRAIN: begin
                we          = 1'b1;
                wa          = wr_ptr_reg;
                wd          = head_d;
                ctrl.shift  = 1'b1;
                wr_ptr_next = AW'({1'b0, wr_ptr_reg} + (AW+1)'(step));
                j_next      = j_reg + CW'(1);
                if (j_reg == line_len - CW'(1)) begin
                    j_next = '0;
                    if (line_reg == line_cnt - CW'(1)) begin
                        // At the last line the row pass hands over to the column pass, or the column pass ends.
                        line_next     = '0;
                        base_next     = '0;
                        rd_ptr_next   = '0;
                        col_pass_next = 1'b1;
                        eidx_next     = '0;
                    end else begin
                        line_next = line_reg + CW'(1);
                        base_next = col_pass_reg ? AW'({1'b0, base_reg} + (AW+1)'(1))
                                                 : AW'({1'b0, base_reg} + (AW+1)'(cols_c));
                        rd_ptr_next = base_next;
                    end
                end
            end
            mrcs_pkg::ST_EMIT_RD: begin
                rd_ptr_next = eidx_reg[AW-1:0];
            end
            mrcs_pkg::ST_EMIT_LD: ;
            mrcs_pkg::ST_EMIT_WAIT: begin
                // Point the read port at the next element before its read cycle.
                if (m_ready) begin
                    eidx_next   = eidx_reg + PW'(1);
                    rd_ptr_next = eidx_next[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mrcs_pkg::ST_LOAD;
            pos_reg      <= '0;
            col_pass_reg <= 1'b0;
            ins_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            j_reg        <= '0;
            line_reg     <= '0;
            settle_reg   <= '0;
            eidx_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            col_pass_reg <= col_pass_next;
            ins_pend_reg <= (state_reg == mrcs_pkg::ST_FEED);
            j_reg        <= j_next;
            line_reg     <= line_next;
            settle_reg   <= settle_next;
            eidx_reg     <= eidx_next;
            if (state_reg == mrcs_pkg::ST_EMIT_LD) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
        rd_ptr_reg <= rd_ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        base_reg   <= base_next;
        if (state_reg == mrcs_pkg::ST_EMIT_LD) begin
            out_reg.sorted_value <= rdata_reg;
            out_reg.final_res    <= (eidx_reg == n_elem - PW'(1));
        end
    end

    // Element store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        rdata_reg <= mem[rd_ptr_reg];
    end

    mrcs_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .ins_d   (rdata_reg),
        .head_d  (head_d)
    );

    assign s_ready = (state_reg == mrcs_pkg::ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_valid_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == mrcs_pkg::ST_EMIT_WAIT))
        else $error("result valid outside of the emit wait state");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= PW'(mrcs_pkg::STORE_DEPTH))
        else $error("load position ran past the store depth");
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.last) |=> (pos_reg == '0 && !s_ready))
        else $error("last item did not start the sort");
    a_final_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.final_res) |=> s_ready)
        else $error("block did not return to loading after the final result");
`endif

endmodule

[verif/matrix_row_col_sort_test.sv]
// Self-checking testbench for matrix_row_col_sort: random matrices, sizes and handshake gaps.
// Depends on mrcs_pkg and the matrix_row_col_sort RTL; results are predicted by the sort_board class.
module matrix_row_col_sort_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Holds a private copy of the element store and the size registers, and the
    // queue of sorted elements that the block still owes.
    class sort_board;
        logic [mrcs_pkg::DATA_W-1:0] store [mrcs_pkg::STORE_DEPTH];
        bit                          written [mrcs_pkg::STORE_DEPTH];
        int unsigned                 load_pos;
        logic [mrcs_pkg::CNT_W-1:0]  row_reg, col_reg;
        mrcs_pkg::out_item_t         owed [$];
        int                          errors;
        int                          checked;

        function new();
            load_pos = 0;
            row_reg  = 8;
            col_reg  = 8;
            errors   = 0;
            checked  = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function int eff(logic [mrcs_pkg::CNT_W-1:0] v, int maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int rows();
            return eff(row_reg, mrcs_pkg::MAX_ROWS);
        endfunction

        function int cols();
            return eff(col_reg, mrcs_pkg::MAX_COLS);
        endfunction

        function bit filled(int n);
            for (int i = 0; i < n; i++)
                if (!written[i]) return 0;
            return 1;
        endfunction

        function void set_reg(logic addr, logic [mrcs_pkg::CNT_W-1:0] v);
            if (addr == mrcs_pkg::REG_ROW_COUNT) row_reg = v;
            else col_reg = v;
        endfunction

        // Insertion through a row or column; stride selects which.
        function void sort_line(int base, int stride, int len, bit descend);
            logic signed [mrcs_pkg::DATA_W-1:0] key, prev;
            int k;
            for (int j = 1; j < len; j++) begin
                key = store[base + j*stride];
                k = j;
                while (k > 0) begin
                    prev = store[base + (k-1)*stride];
                    if (descend ? (key > prev) : (prev > key)) begin
                        store[base + k*stride] = prev;
                        k--;
                    end else begin
                        break;
                    end
                end
                store[base + k*stride] = key;
            end
        endfunction

        function void note_input(mrcs_pkg::in_item_t it);
            int r, c, n;
            mrcs_pkg::out_item_t o;
            r = rows();
            c = cols();
            n = r * c;
            if (load_pos < n) begin
                store[load_pos]   = it.value;
                written[load_pos] = 1;
            end
            if (load_pos < mrcs_pkg::STORE_DEPTH) load_pos++;
            if (it.last) begin
                for (int i = 0; i < r; i++) sort_line(i*c, 1, c, 0);
                for (int i = 0; i < c; i++) sort_line(i, c, r, 1);
                for (int i = 0; i < n; i++) begin
                    o.sorted_value = store[i];
                    o.final_res    = (i == n - 1);
                    owed.push_back(o);
                end
                load_pos = 0;
            end
        endfunction

        function void check_result(mrcs_pkg::out_item_t got);
            mrcs_pkg::out_item_t want;
            checked++;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item %0d/%0b", $time,
                         got.sorted_value, got.final_res);
                return;
            end
            want = owed.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                errors++;
                $display("%0t: sorted_value expected %0d, got %0d", $time,
                         want.sorted_value, got.sorted_value);
            end
            if (got.final_res !== want.final_res) begin
                errors++;
                $display("%0t: final_res expected %0b, got %0b", $time,
                         want.final_res, got.final_res);
            end
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    mrcs_pkg::in_item_t          s_data;
    logic                        m_valid;
    logic                        m_ready;
    mrcs_pkg::out_item_t         m_data;
    logic                        cfg_wen;
    logic                        cfg_addr;
    logic [mrcs_pkg::CNT_W-1:0]  cfg_wdata;

    sort_board board;
    int        items_sent;
    int        matrices;
    bit        calm;
    bit        hold_sink;

    matrix_row_col_sort i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function int draw_gap();
        if (calm) return 0;
        return $urandom_range(0, 14);
    endfunction

    function logic [mrcs_pkg::DATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function logic [mrcs_pkg::CNT_W-1:0] draw_count();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(9, 15);
            2:       return 8;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge after acceptance.
    task send_item(logic [mrcs_pkg::DATA_W-1:0] v, logic lst);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1;
        s_data.value <= v;
        s_data.last  <= lst;
        do @(posedge aclk); while (!s_ready);
        board.note_input('{value: v, last: lst});
        items_sent++;
        @(negedge aclk);
    endtask

    task wait_drained();
        s_valid <= 0;
        while (board.owed.size() != 0) @(negedge aclk);
        // Let the block settle back into loading before touching registers.
        repeat (20) @(negedge aclk);
    endtask

    task write_sizes(logic [mrcs_pkg::CNT_W-1:0] r, logic [mrcs_pkg::CNT_W-1:0] c);
        wait_drained();
        cfg_wen   <= 1;
        cfg_addr  <= mrcs_pkg::REG_ROW_COUNT;
        cfg_wdata <= r;
        @(negedge aclk);
        cfg_addr  <= mrcs_pkg::REG_COL_COUNT;
        cfg_wdata <= c;
        @(negedge aclk);
        cfg_wen   <= 0;
        board.set_reg(mrcs_pkg::REG_ROW_COUNT, r);
        board.set_reg(mrcs_pkg::REG_COL_COUNT, c);
    endtask

    // Sends count elements with last on the final one.
    task send_matrix(int count);
        for (int i = 0; i < count; i++)
            send_item(draw_value(), i == count - 1);
        matrices++;
    endtask

    // Result side: random stalls, and one long hold when requested.
    initial begin
        int stall;
        m_ready <= 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                hold_sink = 0;
            end else begin
                stall = draw_gap();
                if (stall > 0) begin
                    m_ready <= 0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_data);
        end
    end

    initial begin
        int n, shape;
        board      = new();
        items_sent = 0;
        matrices   = 0;
        calm       = 0;
        hold_sink  = 0;
        aresetn    <= 0;
        s_valid    <= 0;
        s_data     <= '0;
        cfg_wen    <= 0;
        cfg_addr   <= mrcs_pkg::REG_ROW_COUNT;
        cfg_wdata  <= '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Single elements at both ends of the value range.
        write_sizes(1, 1);
        send_item(32'h7fff_ffff, 1);
        send_item(32'h8000_0000, 1);
        // Zero rows acts as one, fifteen columns as eight.
        write_sizes(0, 15);
        send_item(32'h8000_0000, 0);
        send_item(32'h7fff_ffff, 0);
        send_item(0, 0);
        send_item(32'hffff_ffff, 0);
        send_item(32'h7fff_ffff, 0);
        send_item(1, 0);
        send_item(32'h8000_0000, 0);
        send_item(32'hffff_ffff, 1);
        // Fifteen rows acts as eight, zero columns as one.
        write_sizes(15, 0);
        send_matrix(8);
        // Surplus elements beyond the matrix are dropped.
        write_sizes(2, 1);
        send_matrix(4);
        // A short matrix reuses what the store kept from the previous sort.
        send_item(32'h5a5a_a5a5, 1);

        // Full 8x8 with the receiver holding off while a short next matrix waits.
        write_sizes(8, 8);
        hold_sink = 1;
        send_matrix(64);
        send_matrix(6);
        // Far too many elements: the load position saturates at the store depth.
        write_sizes(2, 2);
        send_matrix(66);

        while (items_sent < 170) begin
            if ($urandom_range(0, 3) == 0) calm = ~calm;
            if ($urandom_range(0, 2) == 0)
                write_sizes(draw_count(), draw_count());
            n = board.rows() * board.cols();
            shape = $urandom_range(0, 9);
            if (shape == 0 && n < mrcs_pkg::STORE_DEPTH)
                send_matrix(n + $urandom_range(1, 3));
            else if (shape == 1 && n > 1 && board.filled(n))
                send_matrix($urandom_range(1, n - 1));
            else
                send_matrix(n);
        end

        wait_drained();
        repeat (50) @(negedge aclk);
        $display("Sorted %0d matrices from %0d input items, %0d result items checked.",
                 matrices, items_sent, board.checked);
        $display("Sizes covered 1x1 through 8x8, clamped counts, surplus and short loads.");
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
